// ===== sv/wfps_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wfps_pkg: shared types, constants and control store
// Widths, register indexes, maneuver codes, region thresholds and the
// microprogram that sequences one sample through the shared multiplier.
// ---------------------------------------------------------------------------
package wfps_pkg;

    // Field widths
    localparam int SAMPLE_BITS    = 12;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int GAIN_W         = 28;
    localparam int PERIOD_W       = 16;
    localparam int PCT_W          = 7;
    localparam int ERR_W          = SAMPLE_BITS + 1;
    localparam int DIFF_W         = SAMPLE_BITS + 2;
    localparam int SUM_W          = 24;
    localparam int CV_W           = 24;
    localparam int CMP_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 28;

    // Shared multiplier: unsigned A operand, signed B operand
    localparam int MUL_A_W = GAIN_W;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int PID_SHIFT = GAIN_FRAC_BITS - 8;

    // Divide by 100 through a reciprocal: floor(x * RECIP_100 >> RECIP_SHIFT)
    // is exact for x below 2^30/76, which covers period * percent.
    localparam int RECIP_SHIFT = 30;
    localparam logic [MUL_A_W-1:0] RECIP_100 = MUL_A_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
    localparam int SCALE_X_W = PERIOD_W + PCT_W;

    // Saturation limits
    localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sd8388607;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sd8388607;
    localparam logic signed [ACC_W-1:0] CV_MAX  = ACC_W'(64'sd8388607);
    localparam logic signed [ACC_W-1:0] CV_MIN  = ACC_W'(-64'sd8388608);

    // Region thresholds in Q8
    localparam logic signed [CV_W-1:0] V_POS_25  = 24'sd6400;
    localparam logic signed [CV_W-1:0] V_POS_27  = 24'sd6912;
    localparam logic signed [CV_W-1:0] V_POS_20  = 24'sd5120;
    localparam logic signed [CV_W-1:0] V_NEG_20  = -24'sd5120;
    localparam logic signed [CV_W-1:0] V_NEG_50  = -24'sd12800;
    localparam logic signed [CV_W-1:0] V_NEG_80  = -24'sd20480;
    localparam logic signed [CV_W-1:0] V_NEG_100 = -24'sd25600;

    localparam logic [SAMPLE_BITS-1:0] FRONT_1000 = SAMPLE_BITS'(1000);
    localparam logic [SAMPLE_BITS-1:0] FRONT_1400 = SAMPLE_BITS'(1400);
    localparam logic [SAMPLE_BITS-1:0] FRONT_1500 = SAMPLE_BITS'(1500);
    localparam logic [SAMPLE_BITS-1:0] FRONT_1800 = SAMPLE_BITS'(1800);
    localparam logic [SAMPLE_BITS-1:0] FRONT_2000 = SAMPLE_BITS'(2000);

    // Maneuver duty percents
    localparam logic [PCT_W-1:0] PCT_99 = 7'd99;
    localparam logic [PCT_W-1:0] PCT_80 = 7'd80;
    localparam logic [PCT_W-1:0] PCT_75 = 7'd75;
    localparam logic [PCT_W-1:0] PCT_70 = 7'd70;
    localparam logic [PCT_W-1:0] PCT_65 = 7'd65;
    localparam logic [PCT_W-1:0] PCT_17 = 7'd17;

    // Maneuver codes
    localparam logic [2:0] MAN_HOLD     = 3'd0;
    localparam logic [2:0] MAN_UTURN    = 3'd1;
    localparam logic [2:0] MAN_LEFT     = 3'd2;
    localparam logic [2:0] MAN_RIGHT    = 3'd3;
    localparam logic [2:0] MAN_SHARP    = 3'd4;
    localparam logic [2:0] MAN_STRAIGHT = 3'd5;
    localparam logic [2:0] MAN_SPECIAL  = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 3'd5;

    // Payload types
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] right_distance;
        logic [SAMPLE_BITS-1:0] front_distance;
    } in_item_t;

    typedef struct packed {
        logic [2:0]             maneuver;
        logic                   left_forward;
        logic [CMP_W-1:0]       left_compare;
        logic [CMP_W-1:0]       right_compare;
        logic signed [CV_W-1:0] control_value;
        logic                   log_valid;
        logic [11:0]            abs_error;
    } out_item_t;

    // Control word
    localparam int STEP_W = 4;

    typedef enum logic [2:0] {A_GP, A_GI, A_GD, A_PERIOD, A_RECIP} a_sel_t;
    typedef enum logic [2:0] {B_ERR, B_SUM, B_DIFF, B_LPCT, B_RPCT, B_PROD} b_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {COND_NONE, COND_WAIT_IN, COND_WAIT_OUT} cond_t;

    typedef struct packed {
        logic              take;
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        logic              mul_en;
        acc_op_t           acc_op;
        logic              v_load;
        logic              decide;
        logic              lcmp_load;
        logic              rcmp_load;
        logic              emit;
        cond_t             cond;
        logic              last;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd12;

    // Microprogram: one control word per step
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{take: 1'b0, a_sel: A_GP, b_sel: B_ERR, mul_en: 1'b0, acc_op: ACC_HOLD,
              v_load: 1'b0, decide: 1'b0, lcmp_load: 1'b0, rcmp_load: 1'b0,
              emit: 1'b0, cond: COND_NONE, last: 1'b0, target: STEP_WAIT};
        unique case (step)
            4'd0:
            begin
                w.take = 1'b1;
                w.cond = COND_WAIT_IN;
            end
            4'd1:
            begin
                w.mul_en = 1'b1; w.a_sel = A_GP; w.b_sel = B_ERR;
            end
            4'd2:
            begin
                w.mul_en = 1'b1; w.a_sel = A_GI; w.b_sel = B_SUM; w.acc_op = ACC_LOAD;
            end
            4'd3:
            begin
                w.mul_en = 1'b1; w.a_sel = A_GD; w.b_sel = B_DIFF; w.acc_op = ACC_ADD;
            end
            4'd4:
            begin
                w.acc_op = ACC_ADD;
            end
            4'd5:
            begin
                w.v_load = 1'b1;
            end
            4'd6:
            begin
                w.decide = 1'b1;
            end
            4'd7:
            begin
                w.mul_en = 1'b1; w.a_sel = A_PERIOD; w.b_sel = B_LPCT;
            end
            4'd8:
            begin
                w.mul_en = 1'b1; w.a_sel = A_RECIP; w.b_sel = B_PROD;
            end
            4'd9:
            begin
                w.mul_en = 1'b1; w.a_sel = A_PERIOD; w.b_sel = B_RPCT; w.lcmp_load = 1'b1;
            end
            4'd10:
            begin
                w.mul_en = 1'b1; w.a_sel = A_RECIP; w.b_sel = B_PROD;
            end
            4'd11:
            begin
                w.rcmp_load = 1'b1;
            end
            4'd12:
            begin
                w.emit = 1'b1; w.cond = COND_WAIT_OUT; w.target = STEP_EMIT; w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== sv/wfps_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wfps_mul: shared registered multiplier
// Multiplies an unsigned A operand by a signed B operand and registers the
// product when enabled.
// ---------------------------------------------------------------------------
module wfps_mul (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [wfps_pkg::MUL_A_W-1:0]      a,
    input  wire logic signed [wfps_pkg::MUL_B_W-1:0] b,
    output logic signed [wfps_pkg::PROD_W-1:0]     prod
);

    logic signed [wfps_pkg::PROD_W-1:0] prod_reg;
    logic signed [wfps_pkg::PROD_W-1:0] prod_next;

    // Form the signed product of the zero-extended A and B
    always_comb
    begin
        prod_next = $signed({1'b0, a}) * b;
    end

    // Hold the product until the next enabled step
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== sv/wall_follow_pid_steering.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wall_follow_pid_steering: PID wall-following steering controller
// Forms a PID value from the right sensor error, picks a maneuver from the
// PID value and front distance, and scales duty percents to PWM counts.
// ---------------------------------------------------------------------------
// One sample is accepted on the input channel when the sequencer sits at its
// wait step; its result is loaded into the output register at the emit step,
// and the next sample is taken the cycle after the result is loaded, so the
// block takes no new sample while one is still in flight. The sequencing comes
// from the single shared multiplier, which forms the three PID products and
// the two duty scalings (period * percent, then a reciprocal multiply for the
// divide by 100) one after another. A result left waiting on the output holds
// the sequencer at its final step. Configuration writes take effect at once
// and are meant for idle periods; writing the cruise percent loads both motor
// duties only until the first maneuver is chosen.
// ---------------------------------------------------------------------------
module wall_follow_pid_steering (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [wfps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wfps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire wfps_pkg::in_item_t                   in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output wfps_pkg::out_item_t                       out_data
);

    // Configuration registers
    logic [wfps_pkg::SAMPLE_BITS-1:0] target_reg;
    logic [wfps_pkg::GAIN_W-1:0]      gain_p_reg;
    logic [wfps_pkg::GAIN_W-1:0]      gain_i_reg;
    logic [wfps_pkg::GAIN_W-1:0]      gain_d_reg;
    logic [wfps_pkg::PERIOD_W-1:0]    period_reg;

    // Controller state
    logic [wfps_pkg::STEP_W-1:0]      step_reg;
    logic [wfps_pkg::STEP_W-1:0]      step_next;
    logic signed [wfps_pkg::SUM_W-1:0] sum_reg;
    logic signed [wfps_pkg::ERR_W-1:0] prev_reg;
    logic                             log_phase_reg;
    logic [wfps_pkg::PCT_W-1:0]       lpct_reg;
    logic [wfps_pkg::PCT_W-1:0]       rpct_reg;
    logic                             ldir_reg;
    logic                             seen_reg;
    logic                             out_valid_reg;
    wfps_pkg::out_item_t              out_reg;

    // Datapath registers
    logic [wfps_pkg::SAMPLE_BITS-1:0]  front_reg;
    logic signed [wfps_pkg::ERR_W-1:0] err_reg;
    logic signed [wfps_pkg::DIFF_W-1:0] diff_reg;
    logic signed [wfps_pkg::ACC_W-1:0] acc_reg;
    logic signed [wfps_pkg::CV_W-1:0]  v_reg;
    logic [2:0]                        man_reg;
    logic [wfps_pkg::CMP_W-1:0]        lcmp_reg;
    logic [wfps_pkg::CMP_W-1:0]        rcmp_reg;

    // Combinational signals
    wfps_pkg::ctrl_t                   ctrl;
    logic                              accept;
    logic                              out_busy;
    logic                              jump;
    logic signed [wfps_pkg::ERR_W-1:0] err_new;
    logic signed [wfps_pkg::SUM_W:0]   sum_wide;
    logic signed [wfps_pkg::SUM_W-1:0] sum_sat;
    logic [wfps_pkg::MUL_A_W-1:0]      mul_a;
    logic signed [wfps_pkg::MUL_B_W-1:0] mul_b;
    logic signed [wfps_pkg::PROD_W-1:0] prod;
    logic signed [wfps_pkg::ACC_W-1:0] prod_ext;
    logic signed [wfps_pkg::ACC_W-1:0] acc_sh;
    logic signed [wfps_pkg::CV_W-1:0]  v_sat;
    logic [wfps_pkg::PROD_W-wfps_pkg::RECIP_SHIFT-1:0] quot;
    logic [wfps_pkg::CMP_W-1:0]        cmp_sat;
    logic [2:0]                        man_new;
    logic [wfps_pkg::PCT_W-1:0]        lpct_new;
    logic [wfps_pkg::PCT_W-1:0]        rpct_new;
    logic                              ldir_new;
    logic [wfps_pkg::ERR_W-1:0]        abs_err;

    // Decode the current control word
    always_comb
    begin
        ctrl = wfps_pkg::ucode(step_reg);
    end

    assign in_ready = ctrl.take;
    assign accept   = in_valid && ctrl.take;
    assign out_busy = out_valid_reg && !out_ready;

    // Advance the step counter: conditional jump, wrap after the last step
    always_comb
    begin
        case (ctrl.cond)
            wfps_pkg::COND_WAIT_IN:  jump = !in_valid;
            wfps_pkg::COND_WAIT_OUT: jump = out_busy;
            default:                 jump = 1'b0;
        endcase
        if (jump)
        begin
            step_next = ctrl.target;
        end
        else if (ctrl.last)
        begin
            step_next = wfps_pkg::STEP_WAIT;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // Form the error and the saturated error sum for the incoming sample
    always_comb
    begin
        err_new  = $signed({1'b0, in_data.right_distance}) - $signed({1'b0, target_reg});
        sum_wide = (wfps_pkg::SUM_W + 1)'(sum_reg) + (wfps_pkg::SUM_W + 1)'(err_new);
        if (sum_wide > (wfps_pkg::SUM_W + 1)'(wfps_pkg::SUM_MAX))
        begin
            sum_sat = wfps_pkg::SUM_MAX;
        end
        else if (sum_wide < (wfps_pkg::SUM_W + 1)'(wfps_pkg::SUM_MIN))
        begin
            sum_sat = wfps_pkg::SUM_MIN;
        end
        else
        begin
            sum_sat = sum_wide[wfps_pkg::SUM_W-1:0];
        end
    end

    // Select multiplier operands
    always_comb
    begin
        case (ctrl.a_sel)
            wfps_pkg::A_GP:     mul_a = gain_p_reg;
            wfps_pkg::A_GI:     mul_a = gain_i_reg;
            wfps_pkg::A_GD:     mul_a = gain_d_reg;
            wfps_pkg::A_PERIOD: mul_a = wfps_pkg::MUL_A_W'(period_reg);
            default:            mul_a = wfps_pkg::RECIP_100;
        endcase
        case (ctrl.b_sel)
            wfps_pkg::B_ERR:  mul_b = wfps_pkg::MUL_B_W'(err_reg);
            wfps_pkg::B_SUM:  mul_b = wfps_pkg::MUL_B_W'(sum_reg);
            wfps_pkg::B_DIFF: mul_b = wfps_pkg::MUL_B_W'(diff_reg);
            wfps_pkg::B_LPCT: mul_b = $signed(wfps_pkg::MUL_B_W'(lpct_reg));
            wfps_pkg::B_RPCT: mul_b = $signed(wfps_pkg::MUL_B_W'(rpct_reg));
            default:
                mul_b = $signed(wfps_pkg::MUL_B_W'(prod[wfps_pkg::SCALE_X_W-1:0]));
        endcase
    end

    wfps_mul u_mul (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Shift the PID sum down to Q8 and saturate; saturate the scaled count
    always_comb
    begin
        prod_ext = wfps_pkg::ACC_W'(prod);
        acc_sh   = acc_reg >>> wfps_pkg::PID_SHIFT;
        if (acc_sh > wfps_pkg::CV_MAX)
        begin
            v_sat = wfps_pkg::CV_W'(wfps_pkg::CV_MAX);
        end
        else if (acc_sh < wfps_pkg::CV_MIN)
        begin
            v_sat = wfps_pkg::CV_W'(wfps_pkg::CV_MIN);
        end
        else
        begin
            v_sat = acc_sh[wfps_pkg::CV_W-1:0];
        end
        quot = prod[wfps_pkg::PROD_W-1:wfps_pkg::RECIP_SHIFT];
        if (|quot[$bits(quot)-1:wfps_pkg::CMP_W])
        begin
            cmp_sat = '1;
        end
        else
        begin
            cmp_sat = quot[wfps_pkg::CMP_W-1:0];
        end
    end

    // Pick the maneuver from the first matching region
    always_comb
    begin
        man_new  = wfps_pkg::MAN_HOLD;
        lpct_new = lpct_reg;
        rpct_new = rpct_reg;
        ldir_new = ldir_reg;
        if (v_reg < wfps_pkg::V_POS_25 && front_reg > wfps_pkg::FRONT_2000)
        begin
            man_new = wfps_pkg::MAN_UTURN; ldir_new = 1'b0;
            lpct_new = wfps_pkg::PCT_99; rpct_new = wfps_pkg::PCT_99;
        end
        else if (v_reg > wfps_pkg::V_POS_27 && front_reg < wfps_pkg::FRONT_1000)
        begin
            man_new = wfps_pkg::MAN_LEFT; ldir_new = 1'b1;
            lpct_new = wfps_pkg::PCT_70; rpct_new = wfps_pkg::PCT_80;
        end
        else if (v_reg > wfps_pkg::V_NEG_80 && v_reg < wfps_pkg::V_NEG_20
                 && front_reg < wfps_pkg::FRONT_1000)
        begin
            man_new = wfps_pkg::MAN_RIGHT; ldir_new = 1'b1;
            lpct_new = wfps_pkg::PCT_75; rpct_new = wfps_pkg::PCT_65;
        end
        else if (v_reg < wfps_pkg::V_NEG_100 && front_reg < wfps_pkg::FRONT_1400)
        begin
            man_new = wfps_pkg::MAN_SHARP; ldir_new = 1'b1;
            lpct_new = wfps_pkg::PCT_99; rpct_new = wfps_pkg::PCT_17;
        end
        else if (v_reg > wfps_pkg::V_NEG_20 && v_reg < wfps_pkg::V_POS_20
                 && front_reg < wfps_pkg::FRONT_1800)
        begin
            man_new = wfps_pkg::MAN_STRAIGHT; ldir_new = 1'b1;
            lpct_new = wfps_pkg::PCT_70; rpct_new = wfps_pkg::PCT_70;
        end
        else if (v_reg > wfps_pkg::V_NEG_50 && v_reg < 0
                 && front_reg > wfps_pkg::FRONT_1000 && front_reg < wfps_pkg::FRONT_1500)
        begin
            man_new = wfps_pkg::MAN_SPECIAL; ldir_new = 1'b1;
            lpct_new = wfps_pkg::PCT_80; rpct_new = wfps_pkg::PCT_80;
        end
    end

    assign abs_err = err_reg[wfps_pkg::ERR_W-1] ? wfps_pkg::ERR_W'(-err_reg)
                                                : wfps_pkg::ERR_W'(err_reg);

    // Hold configuration, sequencer and steering state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= wfps_pkg::SAMPLE_BITS'(2000);
            gain_p_reg    <= wfps_pkg::GAIN_W'(838861);
            gain_i_reg    <= wfps_pkg::GAIN_W'(1678);
            gain_d_reg    <= wfps_pkg::GAIN_W'(25165824);
            period_reg    <= wfps_pkg::PERIOD_W'(61);
            step_reg      <= wfps_pkg::STEP_WAIT;
            sum_reg       <= '0;
            prev_reg      <= '0;
            log_phase_reg <= 1'b1;
            lpct_reg      <= wfps_pkg::PCT_80;
            rpct_reg      <= wfps_pkg::PCT_80;
            ldir_reg      <= 1'b1;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            // Apply configuration writes; unknown indexes are dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    wfps_pkg::REG_TARGET:
                        target_reg <= cfg_data[wfps_pkg::SAMPLE_BITS-1:0];
                    wfps_pkg::REG_GAIN_P: gain_p_reg <= cfg_data[wfps_pkg::GAIN_W-1:0];
                    wfps_pkg::REG_GAIN_I: gain_i_reg <= cfg_data[wfps_pkg::GAIN_W-1:0];
                    wfps_pkg::REG_GAIN_D: gain_d_reg <= cfg_data[wfps_pkg::GAIN_W-1:0];
                    wfps_pkg::REG_PERIOD: period_reg <= cfg_data[wfps_pkg::PERIOD_W-1:0];
                    wfps_pkg::REG_CRUISE:
                    begin
                        // The cruise duty only matters until the first maneuver
                        if (!seen_reg)
                        begin
                            lpct_reg <= cfg_data[wfps_pkg::PCT_W-1:0];
                            rpct_reg <= cfg_data[wfps_pkg::PCT_W-1:0];
                            ldir_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Update error history on the input transaction
            if (accept)
            begin
                sum_reg  <= sum_sat;
                prev_reg <= err_new;
            end

            // Latch the chosen maneuver's drive
            if (ctrl.decide && man_new != wfps_pkg::MAN_HOLD)
            begin
                lpct_reg <= lpct_new;
                rpct_reg <= rpct_new;
                ldir_reg <= ldir_new;
                seen_reg <= 1'b1;
            end

            // Load the output register or drop it once taken
            if (ctrl.emit && !out_busy)
            begin
                out_valid_reg <= 1'b1;
                log_phase_reg <= !log_phase_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg <= in_data.front_distance;
            err_reg   <= err_new;
            diff_reg  <= wfps_pkg::DIFF_W'(err_new) - wfps_pkg::DIFF_W'(prev_reg);
        end
        case (ctrl.acc_op)
            wfps_pkg::ACC_LOAD: acc_reg <= prod_ext;
            wfps_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:
            begin
            end
        endcase
        if (ctrl.v_load)
        begin
            v_reg <= v_sat;
        end
        if (ctrl.decide)
        begin
            man_reg <= man_new;
        end
        if (ctrl.lcmp_load)
        begin
            lcmp_reg <= cmp_sat;
        end
        if (ctrl.rcmp_load)
        begin
            rcmp_reg <= cmp_sat;
        end
        if (ctrl.emit && !out_busy)
        begin
            out_reg.maneuver      <= man_reg;
            out_reg.left_forward  <= ldir_reg;
            out_reg.left_compare  <= lcmp_reg;
            out_reg.right_compare <= rcmp_reg;
            out_reg.control_value <= v_reg;
            out_reg.log_valid     <= !log_phase_reg;
            out_reg.abs_error     <= log_phase_reg ? 12'd0 : abs_err[11:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A transaction on the input starts the program at its first work step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step_reg == wfps_pkg::STEP_WAIT + 1'b1))
        else $error("sequencer did not start after input transaction");

    // A new result appears only from the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(step_reg) == wfps_pkg::STEP_EMIT))
        else $error("result loaded outside the emit step");

    // The error sum stays inside its symmetric clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg >= wfps_pkg::SUM_MIN) && (sum_reg <= wfps_pkg::SUM_MAX))
        else $error("error sum outside saturation range");

    // Once a maneuver is chosen, the flag stays set
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(seen_reg))
        else $error("maneuver-seen flag cleared");

    // No input is taken while the program is running
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (step_reg == wfps_pkg::STEP_WAIT))
        else $error("input ready outside the wait step");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the wall-following PID steering block
// Drives distance samples over a valid/ready channel with random gaps and
// output back-pressure, retunes the registers between phases, and checks
// every drive result field by field against an in-bench steering predictor or a fixed expected drive.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int    QUIET_LIMIT = 2000;
    localparam longint SUM_LIMIT  = 8388607;
    localparam longint CV_HIGH    = 8388607;
    localparam longint CV_LOW     = -8388608;
    localparam int    CV_SHIFT    = wfps_pkg::PID_SHIFT;
    localparam longint Q8         = 256;

    // Register indexes the block does not decode
    localparam logic [wfps_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [wfps_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Reset values of the registers
    localparam logic [27:0] DEF_TARGET = 28'd2000;
    localparam logic [27:0] DEF_KP     = 28'd838861;
    localparam logic [27:0] DEF_KI     = 28'd1678;
    localparam logic [27:0] DEF_KD     = 28'd25165824;
    localparam logic [27:0] DEF_PERIOD = 28'd61;
    localparam logic [27:0] DEF_CRUISE = 28'd80;

    localparam int NUM_PHASES  = 20;
    localparam int CLIMB_PHASE = 5;
    localparam int DIVE_PHASE  = 6;
    localparam int LONG_RUN    = 180;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum {MODE_TRACK, MODE_CLIMB, MODE_DIVE} sample_mode_t;

    typedef struct {
        row_kind_t                       kind;
        logic [wfps_pkg::CFG_IDX_W-1:0]  idx;
        logic [wfps_pkg::CFG_DATA_W-1:0] data;
        wfps_pkg::in_item_t              item;
        bit                              typed;
        wfps_pkg::out_item_t             want;
    } plan_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [wfps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wfps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    wfps_pkg::in_item_t              in_data = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    wfps_pkg::out_item_t             out_data;

    // Predictor copy of the registers
    longint tgt_dist, kp, ki, kd, period_cnt, cruise_pct;
    // Predictor copy of the block state
    longint sum_acc, last_err, hold_lp, hold_rp;
    bit     log_toggle, hold_fwd, steered;

    wfps_pkg::out_item_t due_drives[$];
    plan_row_t plan[$];
    int        mismatch_count = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;
    bit        steady = 1'b0;

    wall_follow_pid_steering i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // Scale a duty percent to a compare count, saturated
    function automatic logic [wfps_pkg::CMP_W-1:0] duty_count(longint pct);
        longint c;
        c = (period_cnt * pct) / 100;
        if (c > 65535)
            c = 65535;
        return wfps_pkg::CMP_W'(c);
    endfunction

    // Advance the predictor by one sample and return the drive it yields
    function automatic wfps_pkg::out_item_t predict_drive(wfps_pkg::in_item_t s);
        longint              right_v, front_v, err, sum, acc, v, aerr;
        logic [2:0]          man;
        wfps_pkg::out_item_t r;
        right_v = s.right_distance;
        front_v = s.front_distance;
        err = right_v - tgt_dist;
        sum = sum_acc + err;
        if (sum > SUM_LIMIT)
            sum = SUM_LIMIT;
        if (sum < -SUM_LIMIT)
            sum = -SUM_LIMIT;
        acc = kp * err + ki * sum + kd * (err - last_err);
        v = acc >>> CV_SHIFT;
        if (v > CV_HIGH)
            v = CV_HIGH;
        if (v < CV_LOW)
            v = CV_LOW;
        sum_acc = sum;
        last_err = err;

        // Regions in priority order; no match holds the last drive
        man = wfps_pkg::MAN_HOLD;
        if (v < 25 * Q8 && front_v > 2000)
        begin
            man = wfps_pkg::MAN_UTURN; hold_fwd = 1'b0; hold_lp = 99; hold_rp = 99;
        end
        else if (v > 27 * Q8 && front_v < 1000)
        begin
            man = wfps_pkg::MAN_LEFT; hold_fwd = 1'b1; hold_lp = 70; hold_rp = 80;
        end
        else if (v > -80 * Q8 && v < -20 * Q8 && front_v < 1000)
        begin
            man = wfps_pkg::MAN_RIGHT; hold_fwd = 1'b1; hold_lp = 75; hold_rp = 65;
        end
        else if (v < -100 * Q8 && front_v < 1400)
        begin
            man = wfps_pkg::MAN_SHARP; hold_fwd = 1'b1; hold_lp = 99; hold_rp = 17;
        end
        else if (v > -20 * Q8 && v < 20 * Q8 && front_v < 1800)
        begin
            man = wfps_pkg::MAN_STRAIGHT; hold_fwd = 1'b1; hold_lp = 70; hold_rp = 70;
        end
        else if (v > -50 * Q8 && v < 0 && front_v > 1000 && front_v < 1500)
        begin
            man = wfps_pkg::MAN_SPECIAL; hold_fwd = 1'b1; hold_lp = 80; hold_rp = 80;
        end
        if (man != wfps_pkg::MAN_HOLD)
            steered = 1'b1;

        r.log_valid = (log_toggle == 1'b0);
        log_toggle = ~log_toggle;
        aerr = (err < 0) ? -err : err;
        if (aerr > 4095)
            aerr = 4095;

        r.maneuver = man;
        r.left_forward = hold_fwd;
        r.left_compare = duty_count(hold_lp);
        r.right_compare = duty_count(hold_rp);
        r.control_value = wfps_pkg::CV_W'(v);
        r.abs_error = r.log_valid ? 12'(aerr) : 12'd0;
        return r;
    endfunction

    function automatic wfps_pkg::out_item_t hold_drive(logic [wfps_pkg::CMP_W-1:0] cmp,
                                                       logic lv);
        wfps_pkg::out_item_t r;
        r.maneuver = wfps_pkg::MAN_HOLD;
        r.left_forward = 1'b1;
        r.left_compare = cmp;
        r.right_compare = cmp;
        r.control_value = '0;
        r.log_valid = lv;
        r.abs_error = '0;
        return r;
    endfunction

    function automatic void add_item(int rd, int fd);
        plan_row_t p;
        p = '{kind: ROW_ITEM, idx: '0, data: '0, item: '0, typed: 1'b0, want: '0};
        p.item.right_distance = 12'(rd);
        p.item.front_distance = 12'(fd);
        plan.push_back(p);
    endfunction

    function automatic void add_fixed(int rd, int fd, wfps_pkg::out_item_t want);
        add_item(rd, fd);
        plan[$].typed = 1'b1;
        plan[$].want = want;
    endfunction

    function automatic void add_cfg(logic [wfps_pkg::CFG_IDX_W-1:0] idx,
                                    logic [wfps_pkg::CFG_DATA_W-1:0] data);
        plan_row_t p;
        p = '{kind: ROW_CFG, idx: idx, data: data, item: '0, typed: 1'b0, want: '0};
        plan.push_back(p);
    endfunction

    // Mostly short gaps, a few long ones, none in a steady phase
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [27:0] pick_gain(logic [27:0] dflt);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 28'($urandom());
            3, 4: return 28'($urandom_range(0, 32'(dflt) * 4));
            default: return dflt;
        endcase
    endfunction

    function automatic wfps_pkg::in_item_t pick_sample(sample_mode_t mode);
        wfps_pkg::in_item_t s;
        int                 off, f;
        s.right_distance = 12'($urandom());
        s.front_distance = 12'($urandom());
        case (mode)
            MODE_CLIMB:
                if ($urandom_range(0, 9) != 0)
                    s.right_distance = 12'(4095 - $urandom_range(0, 95));
            MODE_DIVE:
                if ($urandom_range(0, 9) != 0)
                    s.right_distance = 12'($urandom_range(0, 95));
            default:
                if ($urandom_range(0, 3) != 0)
                begin
                    // Stay near the wall so the PID value lands in the regions
                    off = int'($urandom_range(0, 400)) - 200 + int'(tgt_dist);
                    if (off < 0)
                        off = 0;
                    if (off > 4095)
                        off = 4095;
                    s.right_distance = 12'(off);
                end
        endcase
        // Put half the front samples on or next to a region edge
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 4))
                0: f = 1000;
                1: f = 1400;
                2: f = 1500;
                3: f = 1800;
                default: f = 2000;
            endcase
            f = f + int'($urandom_range(0, 2)) - 1;
            s.front_distance = 12'(f);
        end
        return s;
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(logic [wfps_pkg::CFG_IDX_W-1:0] idx,
                             logic [wfps_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            wfps_pkg::REG_TARGET: tgt_dist = val[11:0];
            wfps_pkg::REG_GAIN_P: kp = val[27:0];
            wfps_pkg::REG_GAIN_I: ki = val[27:0];
            wfps_pkg::REG_GAIN_D: kd = val[27:0];
            wfps_pkg::REG_PERIOD: period_cnt = val[15:0];
            wfps_pkg::REG_CRUISE:
            begin
                cruise_pct = val[6:0];
                if (!steered)
                begin
                    hold_lp = cruise_pct;
                    hold_rp = cruise_pct;
                    hold_fwd = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Drop valid and hold until every expected drive has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_drives.size() != 0)
            @(posedge clk);
    endtask

    // Offer one sample, record its expected drive once it is taken
    task automatic send_sample(wfps_pkg::in_item_t s, bit typed, wfps_pkg::out_item_t want);
        int                  gap;
        wfps_pkg::out_item_t pred;
        cfg_write <= 1'b0;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        do
            @(posedge clk);
        while (!in_ready);
        pred = predict_drive(s);
        due_drives.push_back(typed ? want : pred);
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Output back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // Compare each result transaction with the oldest expected drive
    always @(posedge clk)
    begin : watch_drives
        wfps_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_drives.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
            end
            else
            begin
                want = due_drives.pop_front();
                check_field("maneuver", want.maneuver, out_data.maneuver);
                check_field("left_forward", want.left_forward, out_data.left_forward);
                check_field("left_compare", want.left_compare, out_data.left_compare);
                check_field("right_compare", want.right_compare, out_data.right_compare);
                check_field("control_value", $signed(want.control_value),
                            $signed(out_data.control_value));
                check_field("log_valid", want.log_valid, out_data.log_valid);
                check_field("abs_error", want.abs_error, out_data.abs_error);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int           ph, n, k;
        sample_mode_t mode;

        tgt_dist = DEF_TARGET;
        kp = DEF_KP;
        ki = DEF_KI;
        kd = DEF_KD;
        period_cnt = DEF_PERIOD;
        cruise_pct = DEF_CRUISE;
        sum_acc = 0;
        last_err = 0;
        log_toggle = 1'b1;
        hold_lp = DEF_CRUISE;
        hold_rp = DEF_CRUISE;
        hold_fwd = 1'b1;
        steered = 1'b0;

        // Directed: cruise drive before any maneuver, then every maneuver
        add_fixed(2000, 1900, hold_drive(16'd48, 1'b0));
        add_cfg(wfps_pkg::REG_PERIOD, 28'd65535);
        add_cfg(wfps_pkg::REG_CRUISE, 28'd127);
        add_fixed(2000, 1900, hold_drive(16'd65535, 1'b1));
        add_cfg(wfps_pkg::REG_CRUISE, 28'd0);
        add_fixed(2000, 1900, hold_drive(16'd0, 1'b0));
        add_cfg(wfps_pkg::REG_PERIOD, DEF_PERIOD);
        add_cfg(wfps_pkg::REG_CRUISE, DEF_CRUISE);
        add_item(2000, 4095);
        add_item(2040, 500);
        add_item(2000, 500);
        add_item(1900, 1300);
        add_item(1900, 1700);
        add_item(1880, 1200);
        add_item(2000, 1900);
        add_item(4095, 4095);
        add_item(0, 0);
        add_item(0, 4095);
        add_item(4095, 0);
        // Undecoded indexes must change nothing
        add_cfg(REG_SPARE_6, 28'h5A5A5A5);
        add_cfg(REG_SPARE_7, '1);
        // Full gains drive the PID value into both rails
        add_cfg(wfps_pkg::REG_TARGET, 28'd0);
        add_cfg(wfps_pkg::REG_GAIN_P, '1);
        add_cfg(wfps_pkg::REG_GAIN_I, '1);
        add_cfg(wfps_pkg::REG_GAIN_D, '1);
        add_item(4095, 0);
        add_item(0, 4095);
        add_cfg(wfps_pkg::REG_TARGET, 28'd4095);
        add_cfg(wfps_pkg::REG_GAIN_P, '0);
        add_cfg(wfps_pkg::REG_GAIN_I, '0);
        add_cfg(wfps_pkg::REG_GAIN_D, '0);
        add_item(0, 1900);
        add_item(4095, 2001);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_sample(plan[i].item, plan[i].typed, plan[i].want);
        end

        // Random phases; two long ones push the error sum far toward each rail
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            steady = ($urandom_range(0, 3) == 0);
            if (ph == CLIMB_PHASE || ph == DIVE_PHASE)
            begin
                mode = (ph == CLIMB_PHASE) ? MODE_CLIMB : MODE_DIVE;
                n = LONG_RUN;
                write_reg(wfps_pkg::REG_TARGET, (ph == CLIMB_PHASE) ? 28'd0 : 28'd4095);
                write_reg(wfps_pkg::REG_GAIN_P, DEF_KP);
                write_reg(wfps_pkg::REG_GAIN_I, DEF_KI);
                write_reg(wfps_pkg::REG_GAIN_D, DEF_KD);
            end
            else
            begin
                mode = MODE_TRACK;
                n = $urandom_range(40, 80);
                case ($urandom_range(0, 9))
                    0: write_reg(wfps_pkg::REG_TARGET, 28'd0);
                    1: write_reg(wfps_pkg::REG_TARGET, 28'd4095);
                    2: write_reg(wfps_pkg::REG_TARGET, DEF_TARGET);
                    default: write_reg(wfps_pkg::REG_TARGET, 28'($urandom_range(0, 4095)));
                endcase
                write_reg(wfps_pkg::REG_GAIN_P, pick_gain(DEF_KP));
                write_reg(wfps_pkg::REG_GAIN_I, pick_gain(DEF_KI));
                write_reg(wfps_pkg::REG_GAIN_D, pick_gain(DEF_KD));
            end
            case ($urandom_range(0, 4))
                0: write_reg(wfps_pkg::REG_PERIOD, 28'd0);
                1: write_reg(wfps_pkg::REG_PERIOD, 28'd65535);
                2: write_reg(wfps_pkg::REG_PERIOD, DEF_PERIOD);
                default: write_reg(wfps_pkg::REG_PERIOD, 28'($urandom_range(0, 65535)));
            endcase
            write_reg(wfps_pkg::REG_CRUISE, 28'($urandom_range(0, 100)));
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 28'($urandom()));
            for (k = 0; k < n; k++)
                send_sample(pick_sample(mode), 1'b0, '0);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && due_drives.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
